/* hw/rtl/planar_bearing_centidegrees_core_assert.svh */
// assertion macros shared by the rtl
`ifndef PLANAR_BEARING_CENTIDEGREES_CORE_ASSERT_SVH
`define PLANAR_BEARING_CENTIDEGREES_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PLBRG_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("plbrg assertion failed");

// consequent must hold in the cycle after the antecedent
`define PLBRG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("plbrg assertion failed");

`endif

/* hw/rtl/plbrg_pkg.sv */
package plbrg_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int STEPS_MAX        = 40;
    localparam int COORD_W          = 32;
    localparam int PRESHIFT         = 24;
    localparam int MAG_W            = 32;
    localparam int X_W              = 60;
    localparam int TURN_W           = 32;
    localparam int Z_W              = TURN_W + 2;
    localparam int BEARING_W        = 16;

    localparam logic [BEARING_W-1:0] BEARING_SPAN = 16'd36000;

    // angles in 2^-32 turn, one bit of headroom for the full turn
    localparam logic [TURN_W:0] QUARTER_TURN = 33'h0_4000_0000;
    localparam logic [TURN_W:0] HALF_TURN    = 33'h0_8000_0000;
    localparam logic [TURN_W:0] FULL_TURN    = 33'h1_0000_0000;

    // atan(2^-i) as a fraction of a full turn
    localparam logic [TURN_W-1:0] ATAN_TURNS [0:STEPS_MAX] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000
    };

    typedef struct packed {
        logic de_neg;
        logic dn_neg;
        logic a_zero;
        logic b_zero;
    } quad_t;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
        quad_t                 quad;
    } cordic_t;

endpackage

/* hw/rtl/plbrg_front.sv */
module plbrg_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [plbrg_pkg::COORD_W-1:0]  from_east,
    input  logic signed [plbrg_pkg::COORD_W-1:0]  from_north,
    input  logic signed [plbrg_pkg::COORD_W-1:0]  to_east,
    input  logic signed [plbrg_pkg::COORD_W-1:0]  to_north,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output plbrg_pkg::cordic_t                    out_data
);
    import plbrg_pkg::*;

    logic                      diff_valid_reg;
    logic signed [COORD_W:0]   de_reg;
    logic signed [COORD_W:0]   dn_reg;
    logic signed [COORD_W:0]   de_next;
    logic signed [COORD_W:0]   dn_next;
    logic                      seed_valid_reg;
    cordic_t                   seed_reg;
    cordic_t                   seed_next;
    logic                      diff_ready;
    logic                      seed_ready;
    logic        [COORD_W:0]   de_abs;
    logic        [COORD_W:0]   dn_abs;

    assign seed_ready = !seed_valid_reg || out_ready;
    assign diff_ready = !diff_valid_reg || seed_ready;
    assign in_ready   = diff_ready;

    // differences at one extra bit so they never wrap
    assign de_next = {to_east[COORD_W-1], to_east} - {from_east[COORD_W-1], from_east};
    assign dn_next = {to_north[COORD_W-1], to_north} - {from_north[COORD_W-1], from_north};

    always_comb begin
        de_abs = de_reg[COORD_W] ? (~de_reg + 1'b1) : de_reg;
        dn_abs = dn_reg[COORD_W] ? (~dn_reg + 1'b1) : dn_reg;
        seed_next.x           = $signed(X_W'({dn_abs[MAG_W-1:0], {PRESHIFT{1'b0}}}));
        seed_next.y           = $signed(X_W'({de_abs[MAG_W-1:0], {PRESHIFT{1'b0}}}));
        seed_next.z           = '0;
        seed_next.quad.de_neg = de_reg[COORD_W];
        seed_next.quad.dn_neg = dn_reg[COORD_W];
        seed_next.quad.a_zero = (de_reg == '0);
        seed_next.quad.b_zero = (dn_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_valid_reg <= 1'b0;
            seed_valid_reg <= 1'b0;
        end else begin
            if (diff_ready) begin
                diff_valid_reg <= in_valid;
            end
            if (seed_ready) begin
                seed_valid_reg <= diff_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && diff_ready) begin
            de_reg <= de_next;
            dn_reg <= dn_next;
        end
        if (diff_valid_reg && seed_ready) begin
            seed_reg <= seed_next;
        end
    end

    assign out_valid = seed_valid_reg;
    assign out_data  = seed_reg;

endmodule

/* hw/rtl/plbrg_cordic_step.sv */
module plbrg_cordic_step #(
    parameter int STEP = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  plbrg_pkg::cordic_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output plbrg_pkg::cordic_t out_data
);
    import plbrg_pkg::*;

    logic                  valid_reg;
    cordic_t               data_reg;
    cordic_t               data_next;
    logic signed [X_W-1:0] x_shift;
    logic signed [X_W-1:0] y_shift;
    logic signed [Z_W-1:0] z_delta;
    logic                  y_pos;
    logic                  y_neg;

    assign in_ready = !valid_reg || out_ready;

    assign x_shift = $signed(in_data.x) >>> STEP;
    assign y_shift = $signed(in_data.y) >>> STEP;
    assign z_delta = $signed(Z_W'(ATAN_TURNS[STEP]));
    assign y_neg   = in_data.y[X_W-1];
    assign y_pos   = !in_data.y[X_W-1] && (in_data.y != '0);

    // rotate towards the x axis; a zero residual stays put
    always_comb begin
        data_next = in_data;
        if (y_pos) begin
            data_next.x = in_data.x + y_shift;
            data_next.y = in_data.y - x_shift;
            data_next.z = in_data.z + z_delta;
        end else if (y_neg) begin
            data_next.x = in_data.x - y_shift;
            data_next.y = in_data.y + x_shift;
            data_next.z = in_data.z - z_delta;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hw/rtl/plbrg_back.sv */
module plbrg_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  plbrg_pkg::cordic_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [plbrg_pkg::BEARING_W-1:0]     bearing
);
    import plbrg_pkg::*;

    logic                            turn_valid_reg;
    logic [TURN_W-1:0]               turn_reg;
    logic [TURN_W-1:0]               turn_next;
    logic                            out_valid_reg;
    logic [BEARING_W-1:0]            bearing_reg;
    logic [TURN_W+BEARING_W-1:0]     product;
    logic                            turn_ready;
    logic                            out_stage_ready;
    logic [TURN_W:0]                 theta;
    logic [TURN_W:0]                 turn_full;

    assign out_stage_ready = !out_valid_reg || out_ready;
    assign turn_ready      = !turn_valid_reg || out_stage_ready;
    assign in_ready        = turn_ready;

    always_comb begin
        // quadrant angle, clamped to a quarter turn, axis cases forced
        if (in_data.quad.a_zero) begin
            theta = '0;
        end else if (in_data.quad.b_zero) begin
            theta = QUARTER_TURN;
        end else if (in_data.z[Z_W-1]) begin
            theta = '0;
        end else if (in_data.z[Z_W-2:0] > QUARTER_TURN) begin
            theta = QUARTER_TURN;
        end else begin
            theta = in_data.z[Z_W-2:0];
        end

        unique case ({in_data.quad.de_neg, in_data.quad.dn_neg})
            2'b00:   turn_full = theta;
            2'b01:   turn_full = HALF_TURN - theta;
            2'b11:   turn_full = HALF_TURN + theta;
            default: turn_full = FULL_TURN - theta;
        endcase

        // a full turn saturates just below it
        turn_next = turn_full[TURN_W] ? {TURN_W{1'b1}} : turn_full[TURN_W-1:0];
    end

    assign product = turn_reg * BEARING_SPAN;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (turn_ready) begin
                turn_valid_reg <= in_valid;
            end
            if (out_stage_ready) begin
                out_valid_reg <= turn_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && turn_ready) begin
            turn_reg <= turn_next;
        end
        if (turn_valid_reg && out_stage_ready) begin
            bearing_reg <= product[TURN_W+BEARING_W-1:TURN_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign bearing   = bearing_reg;

endmodule

/* hw/rtl/planar_bearing_centidegrees_core.sv */
// channel   | ports                                                          | direction
// ----------+----------------------------------------------------------------+----------
// request   | s_valid s_ready s_from_east s_from_north s_to_east s_to_north | in
// result    | m_valid m_ready m_bearing                                      | out
//
// one request per cycle unless m_ready stalls the pipeline; two front stages
// (difference, magnitude), one cordic iteration per stage, then a clamp and
// quadrant stage and a multiply stage whose register drives the result.
// each stage holds its own valid bit and fills a bubble even while a later
// stage is stalled, so s_ready only drops when every stage is full.
// reset clears the valid bits; the data registers are not reset.
`include "planar_bearing_centidegrees_core_assert.svh"

module planar_bearing_centidegrees_core #(
    parameter int CORDIC_STEPS = plbrg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [plbrg_pkg::COORD_W-1:0]  s_from_east,
    input  logic signed [plbrg_pkg::COORD_W-1:0]  s_from_north,
    input  logic signed [plbrg_pkg::COORD_W-1:0]  s_to_east,
    input  logic signed [plbrg_pkg::COORD_W-1:0]  s_to_north,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [plbrg_pkg::BEARING_W-1:0]       m_bearing
);
    import plbrg_pkg::*;

    cordic_t stage_data  [0:CORDIC_STEPS];
    logic    stage_valid [0:CORDIC_STEPS];
    logic    stage_ready [0:CORDIC_STEPS];

    plbrg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .from_east  (s_from_east),
        .from_north (s_from_north),
        .to_east    (s_to_east),
        .to_north   (s_to_north),
        .out_valid  (stage_valid[0]),
        .out_ready  (stage_ready[0]),
        .out_data   (stage_data[0])
    );

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        plbrg_cordic_step #(
            .STEP (k)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    plbrg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stage_valid[CORDIC_STEPS]),
        .in_ready  (stage_ready[CORDIC_STEPS]),
        .in_data   (stage_data[CORDIC_STEPS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .bearing   (m_bearing)
    );

    `PLBRG_ASSERT_IMPL(a_bearing_range, aclk, aresetn, m_valid, m_bearing < BEARING_SPAN)
    `PLBRG_ASSERT_IMPL(a_stall_only_when_full, aclk, aresetn, !s_ready, m_valid && !m_ready)

endmodule
